/* hdl/fanr_pkg.sv */
// shared types, constants and helpers of the framed ascii number receiver
// no dependencies; imported by fanr_parser and the top level
package fanr_pkg;

    localparam int FRAME_BYTES_DEF = 16;
    localparam int TEXT_BYTES_DEF  = 14;
    localparam int SLOT_COUNT_DEF  = 7;

    localparam int POS_W  = 5;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h24;
    localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'h23;
    localparam logic [BYTE_W-1:0] LIMIT_RESET  = 8'd50;
    localparam logic [BYTE_W-1:0] OUT_OF_RANGE = 8'hFF;
    localparam logic [BYTE_W-1:0] MISS_MAX     = 8'hFF;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_POLL = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_HEADER = 2'd0,
        CFG_FOOTER = 2'd1,
        CFG_LIMIT  = 2'd2,
        CFG_SPARE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              values_cleared;
        logic              frame_done;
        logic [BYTE_W-1:0] slot_value;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } digit_t;

    // hex character to digit value
    function automatic digit_t char_value(input logic [BYTE_W-1:0] c);
        digit_t d;
        logic [BYTE_W-1:0] diff;
        d    = '0;
        diff = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            diff = c - 8'h30;
            d.hit = 1'b1;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            diff = c - 8'h37;
            d.hit = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            diff = c - 8'h57;
            d.hit = 1'b1;
        end
        d.value = diff[3:0];
        return d;
    endfunction

endpackage

/* hdl/fanr_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module fanr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 7,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/fanr_parser.sv */
// frame tracking and digit-run scanning, with the staged slot ram
// depends on fanr_pkg and fanr_ram
module fanr_parser
    import fanr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int TEXT_BYTES  = TEXT_BYTES_DEF,
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    parameter int CNT_W  = $clog2(SLOT_COUNT + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_en,
    input  logic              poll_en,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] header_byte,
    input  logic [BYTE_W-1:0] footer_byte,
    output logic              frame_done,
    output logic              frame_ready,
    output logic [CNT_W-1:0]  staged_count,
    input  logic [ADDR_W-1:0] stage_raddr,
    output logic [BYTE_W-1:0] stage_rdata
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              rx_en_reg, rx_en_next;
    logic              ready_reg, ready_next;
    logic [BYTE_W-1:0] acc_reg, acc_next;
    logic              in_num_reg, in_num_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              wr_en;
    logic [BYTE_W-1:0] wr_data;
    logic              store;
    logic [BYTE_W-1:0] store_val;
    logic [POS_W:0]    pos_inc;
    logic              ending;
    logic [BYTE_W-1:0] acc_mul;
    digit_t            dig;

    always_comb begin
        pos_next    = pos_reg;
        rx_en_next  = rx_en_reg;
        ready_next  = ready_reg;
        acc_next    = acc_reg;
        in_num_next = in_num_reg;
        cnt_next    = cnt_reg;
        store       = 1'b0;
        store_val   = acc_reg;
        frame_done  = 1'b0;
        ending      = 1'b0;
        dig         = char_value(rx_byte);
        acc_mul     = (acc_reg << 3) + (acc_reg << 1);
        pos_inc     = {1'b0, pos_reg} + 1'b1;

        if (poll_en) begin
            rx_en_next = 1'b1;
            ready_next = 1'b0;
        end else if (byte_en && rx_en_reg) begin
            if (pos_reg == '0) begin
                if (rx_byte == header_byte) begin
                    acc_next    = '0;
                    in_num_next = 1'b0;
                    cnt_next    = '0;
                    ending      = 1'b1;
                end
            end else begin
                ending = 1'b1;
                if (pos_reg <= POS_W'(TEXT_BYTES)) begin
                    if (!dig.hit) begin
                        store       = in_num_reg;
                        acc_next    = '0;
                        in_num_next = 1'b0;
                    end else begin
                        acc_next    = acc_mul + {4'd0, dig.value};
                        in_num_next = 1'b1;
                        if (pos_reg == POS_W'(TEXT_BYTES)) begin
                            store       = 1'b1;
                            store_val   = acc_next;
                            acc_next    = '0;
                            in_num_next = 1'b0;
                        end
                    end
                end
            end
            // ending here marks that the byte was taken into the frame
            if (ending) begin
                if (rx_byte == footer_byte || pos_inc >= (POS_W+1)'(FRAME_BYTES)) begin
                    if (in_num_next) begin
                        store     = 1'b1;
                        store_val = acc_next;
                    end
                    acc_next    = '0;
                    in_num_next = 1'b0;
                    pos_next    = '0;
                    ready_next  = 1'b1;
                    rx_en_next  = 1'b0;
                    frame_done  = 1'b1;
                end else begin
                    pos_next = pos_inc[POS_W-1:0];
                end
            end
        end

        wr_en   = store && (cnt_next < CNT_W'(SLOT_COUNT));
        wr_data = store_val;
        if (wr_en) begin
            cnt_next = cnt_next + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            rx_en_reg  <= 1'b1;
            ready_reg  <= 1'b0;
            acc_reg    <= '0;
            in_num_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            pos_reg    <= pos_next;
            rx_en_reg  <= rx_en_next;
            ready_reg  <= ready_next;
            acc_reg    <= acc_next;
            in_num_reg <= in_num_next;
            cnt_reg    <= cnt_next;
        end
    end

    fanr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SLOT_COUNT),
        .ADDR_W(ADDR_W)
    ) u_stage_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(cnt_reg[ADDR_W-1:0]),
        .wdata(wr_data),
        .raddr(stage_raddr),
        .rdata(stage_rdata)
    );

    assign frame_ready  = ready_reg;
    assign staged_count = cnt_reg;

endmodule

/* hdl/framed_ascii_number_receiver_top.sv */
// top level of the framed ascii number receiver: command sequencer,
// visible slot ram, miss counting and output register
// depends on fanr_pkg, fanr_ram and fanr_parser
//
//  channel   | direction | transfer condition      | payload
//  s_        | in        | s_tvalid && s_tready    | opcode, rx_byte, slot_index
//  m_        | out       | m_tvalid && m_tready    | slot_value, frame_done, values_cleared
//  cfg_      | in        | cfg_we                  | header, footer, miss limit
//
// byte, miss poll and unused opcode: through ST_EMIT into the output register; slot read:
// through ST_READ, which takes the registered visible ram read data; committing poll:
// through ST_COPY, one slot a cycle through the staged and visible ram ports, then a wait
// for the last write to land
// a new item is taken while the previous result still waits in the output register
// the visible slots read as zero after reset through per-slot valid flags; no clearing pass
module framed_ascii_number_receiver_top
    import fanr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int TEXT_BYTES  = TEXT_BYTES_DEF,
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[1:0], rx_byte[9:2], slot_index[17:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slot_value[7:0], frame_done[8], values_cleared[9]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COPY = 4'b0010,
        ST_READ = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] header_reg, footer_reg, limit_reg;
    logic [BYTE_W-1:0] miss_reg, miss_next;
    logic [SLOT_COUNT-1:0] vld_reg, vld_next;
    result_t           res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg, m_data_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] wa_reg, wa_next;
    logic [ADDR_W-1:0] ra_reg, ra_next;

    logic              accept;
    opcode_t           op;
    logic [BYTE_W-1:0] in_rx;
    logic [BYTE_W-1:0] in_idx;
    logic              byte_en;
    logic              poll_en;
    logic              frame_done;
    logic              frame_ready;
    logic [CNT_W-1:0]  staged_count;
    logic [ADDR_W-1:0] stage_raddr;
    logic [BYTE_W-1:0] stage_rdata;
    logic [ADDR_W-1:0] vis_raddr;
    logic [BYTE_W-1:0] vis_rdata;
    logic [BYTE_W-1:0] miss_inc;
    logic              out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tdata[1:0]);
    assign in_rx    = s_tdata[9:2];
    assign in_idx   = s_tdata[17:10];
    assign byte_en  = accept && (op == OP_BYTE);
    assign poll_en  = accept && (op == OP_POLL);
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            footer_reg <= FOOTER_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_HEADER: header_reg <= cfg_wdata;
                CFG_FOOTER: footer_reg <= cfg_wdata;
                CFG_LIMIT:  limit_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    fanr_parser #(
        .FRAME_BYTES(FRAME_BYTES),
        .TEXT_BYTES (TEXT_BYTES),
        .SLOT_COUNT (SLOT_COUNT),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_en     (byte_en),
        .poll_en     (poll_en),
        .rx_byte     (in_rx),
        .header_byte (header_reg),
        .footer_byte (footer_reg),
        .frame_done  (frame_done),
        .frame_ready (frame_ready),
        .staged_count(staged_count),
        .stage_raddr (stage_raddr),
        .stage_rdata (stage_rdata)
    );

    fanr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SLOT_COUNT),
        .ADDR_W(ADDR_W)
    ) u_visible_ram (
        .aclk (aclk),
        .we   (pend_reg),
        .waddr(wa_reg),
        .wdata(stage_rdata),
        .raddr(vis_raddr),
        .rdata(vis_rdata)
    );

    assign stage_raddr = idx_reg[ADDR_W-1:0];
    assign vis_raddr   = in_idx[ADDR_W-1:0];
    assign miss_inc    = (miss_reg == MISS_MAX) ? MISS_MAX : miss_reg + 1'b1;

    always_comb begin
        state_next   = state_reg;
        miss_next    = miss_reg;
        vld_next     = vld_reg;
        res_next     = res_reg;
        idx_next     = idx_reg;
        pend_next    = 1'b0;
        wa_next      = wa_reg;
        ra_next      = ra_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (pend_reg) begin
            vld_next[wa_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next   = '0;
                    state_next = ST_EMIT;
                    case (op)
                        OP_BYTE: res_next.frame_done = frame_done;
                        OP_POLL: begin
                            if (frame_ready) begin
                                miss_next  = '0;
                                idx_next   = '0;
                                state_next = ST_COPY;
                            end else if (miss_inc > limit_reg) begin
                                miss_next = '0;
                                vld_next  = '0;
                                res_next.values_cleared = 1'b1;
                            end else begin
                                miss_next = miss_inc;
                            end
                        end
                        OP_READ: begin
                            if (in_idx < BYTE_W'(SLOT_COUNT)) begin
                                ra_next    = in_idx[ADDR_W-1:0];
                                state_next = ST_READ;
                            end else begin
                                res_next.slot_value = OUT_OF_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_COPY: begin
                if (idx_reg < staged_count) begin
                    pend_next = 1'b1;
                    wa_next   = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_READ: begin
                res_next.slot_value = vld_reg[ra_reg] ? vis_rdata : '0;
                state_next          = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            miss_reg    <= '0;
            vld_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            miss_reg    <= miss_next;
            vld_reg     <= vld_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        wa_reg     <= wa_next;
        ra_reg     <= ra_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg.values_cleared, m_data_reg.frame_done,
                       m_data_reg.slot_value};

endmodule
